@@ rtl/core/trp_pkg.sv @@
// ----------------------------------------------------------------------------
// Text RAM register port package
// Shared types, register numbers and default sizes of the text RAM port.
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam int unsigned TextDepthDefault = 2048;
  localparam int unsigned WideStepDefault  = 128;

  localparam int unsigned PtrWidth  = 16;
  localparam int unsigned AddrWidth = 11;
  localparam int unsigned DataWidth = 8;

  localparam logic       CmdRead    = 1'b0;
  localparam logic       CmdWrite   = 1'b1;
  localparam logic [2:0] RegControl = 3'd1;
  localparam logic [2:0] RegPointer = 3'd6;
  localparam logic [2:0] RegData    = 3'd7;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 mem_write;
    logic [AddrWidth-1:0] mem_address;
    logic [DataWidth-1:0] mem_data;
    logic [PtrWidth-1:0]  pointer_after;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [PtrWidth-1:0]  addr;
    logic [DataWidth-1:0] data;
  } mem_wr_t;

endpackage

@@ rtl/core/trp_regs.sv @@
// ----------------------------------------------------------------------------
// Text RAM register port register file
// Holds the control byte, the pointer and its byte toggle, and forms the
// result and the text RAM write of each accepted bus access.
// ----------------------------------------------------------------------------
module trp_regs #(
  parameter int unsigned TextDepth = trp_pkg::TextDepthDefault,
  parameter int unsigned WideStep  = trp_pkg::WideStepDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          command_i,
  input  logic [2:0]                    register_index_i,
  input  logic [trp_pkg::DataWidth-1:0] write_data_i,
  output trp_pkg::result_t              result_o,
  output trp_pkg::mem_wr_t              mem_wr_o
);

  localparam logic [trp_pkg::PtrWidth:0] DepthMask = (trp_pkg::PtrWidth + 1)'(TextDepth - 1);
  localparam logic [trp_pkg::PtrWidth-1:0] StepWide = trp_pkg::PtrWidth'(WideStep);
  localparam logic [trp_pkg::PtrWidth-1:0] StepOne  = trp_pkg::PtrWidth'(1);

  logic [7:0]                   control_q, control_d;
  logic [7:0]                   ptr_lo_q, ptr_lo_d;
  logic [7:0]                   ptr_hi_q, ptr_hi_d;
  logic                         hi_next_q, hi_next_d;
  logic [trp_pkg::PtrWidth-1:0] ptr_cur;
  logic [trp_pkg::PtrWidth-1:0] ptr_adv;
  logic [trp_pkg::PtrWidth-1:0] idx;
  logic                         is_data;

  assign ptr_cur = {ptr_hi_q, ptr_lo_q};
  assign idx     = ptr_cur & DepthMask[trp_pkg::PtrWidth-1:0];
  assign ptr_adv = ptr_cur + (control_q[0] ? StepWide : StepOne);
  assign is_data = (command_i == trp_pkg::CmdWrite) && (register_index_i == trp_pkg::RegData);

  always_comb begin
    control_d = control_q;
    ptr_lo_d  = ptr_lo_q;
    ptr_hi_d  = ptr_hi_q;
    hi_next_d = hi_next_q;
    if (fire_i && command_i == trp_pkg::CmdWrite) begin
      case (register_index_i)
        trp_pkg::RegControl: begin
          control_d = write_data_i;
        end
        trp_pkg::RegPointer: begin
          if (hi_next_q) begin
            ptr_hi_d = write_data_i;
          end else begin
            ptr_lo_d = write_data_i;
          end
          hi_next_d = ~hi_next_q;
        end
        trp_pkg::RegData: begin
          ptr_hi_d = ptr_adv[15:8];
          ptr_lo_d = ptr_adv[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_o.read_data     = '0;
    result_o.mem_write     = is_data;
    result_o.mem_address   = is_data ? idx[trp_pkg::AddrWidth-1:0] : '0;
    result_o.mem_data      = is_data ? write_data_i : '0;
    result_o.pointer_after = {ptr_hi_d, ptr_lo_d};
    mem_wr_o.en            = fire_i && is_data;
    mem_wr_o.addr          = idx;
    mem_wr_o.data          = write_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0;
      ptr_lo_q  <= '0;
      ptr_hi_q  <= '0;
      hi_next_q <= 1'b0;
    end else begin
      control_q <= control_d;
      ptr_lo_q  <= ptr_lo_d;
      ptr_hi_q  <= ptr_hi_d;
      hi_next_q <= hi_next_d;
    end
  end

endmodule

@@ rtl/core/trp_text_mem.sv @@
// ----------------------------------------------------------------------------
// Text RAM
// Synchronous byte-wide text memory, written once per data register write.
// ----------------------------------------------------------------------------
module trp_text_mem #(
  parameter int unsigned TextDepth = trp_pkg::TextDepthDefault
) (
  input logic             clk_i,
  input trp_pkg::mem_wr_t mem_wr_i
);

  localparam int unsigned AddrBits = $clog2(TextDepth);

  logic [trp_pkg::DataWidth-1:0] text_mem [TextDepth];

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      text_mem[mem_wr_i.addr[AddrBits-1:0]] <= mem_wr_i.data;
    end
  end

endmodule

@@ rtl/core/trp_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage, so a new transfer is taken while a
// finished result waits downstream.
// ----------------------------------------------------------------------------
module trp_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  trp_pkg::result_t result_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output trp_pkg::result_t result_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  trp_pkg::result_t out_q, out_d;
  trp_pkg::result_t skid_q, skid_d;
  logic             advance;

  assign advance = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (advance) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result_i;
        out_valid_d = in_fire_i;
      end
    end else if (in_fire_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

@@ rtl/core/text_ram_register_port.sv @@
// ----------------------------------------------------------------------------
// Text RAM register port core
// CPU register port into a text RAM with an auto-incrementing pointer.
// ----------------------------------------------------------------------------
// The core takes one bus access transfer per clock unless the input is
// stalled, and returns one registered result transfer for each. Control,
// pointer and toggle updates are registered in the register file, and a
// data write goes to the text RAM in the same cycle, so accesses follow back
// to back without hazards. A two-entry result buffer lets one more transfer
// in while a result is stalled; input stalls only once both entries are full.
module text_ram_register_port_core #(
  parameter int unsigned TextDepth = trp_pkg::TextDepthDefault,
  parameter int unsigned WideStep  = trp_pkg::WideStepDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [2:0]                    register_index_i,
  input  logic [trp_pkg::DataWidth-1:0] write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [trp_pkg::DataWidth-1:0] read_data_o,
  output logic                          mem_write_o,
  output logic [trp_pkg::AddrWidth-1:0] mem_address_o,
  output logic [trp_pkg::DataWidth-1:0] mem_data_o,
  output logic [trp_pkg::PtrWidth-1:0]  pointer_after_o
);

  logic             in_fire;
  logic             buf_full;
  trp_pkg::result_t result;
  trp_pkg::result_t result_out;
  trp_pkg::mem_wr_t mem_wr;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  trp_regs #(
    .TextDepth(TextDepth),
    .WideStep (WideStep)
  ) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .command_i       (command_i),
    .register_index_i(register_index_i),
    .write_data_i    (write_data_i),
    .result_o        (result),
    .mem_wr_o        (mem_wr)
  );

  trp_text_mem #(
    .TextDepth(TextDepth)
  ) u_text_mem (
    .clk_i   (clk_i),
    .mem_wr_i(mem_wr)
  );

  trp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .result_i   (result),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_out)
  );

  assign read_data_o     = result_out.read_data;
  assign mem_write_o     = result_out.mem_write;
  assign mem_address_o   = result_out.mem_address;
  assign mem_data_o      = result_out.mem_data;
  assign pointer_after_o = result_out.pointer_after;

endmodule

@@ rtl/core/trp_checker.sv @@
// ----------------------------------------------------------------------------
// Text RAM register port checker
// Port-level assertions on the input stall and the result channel, bound to the core.
// ----------------------------------------------------------------------------
module trp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [trp_pkg::DataWidth-1:0] read_data_o,
  input logic                          mem_write_o,
  input logic [trp_pkg::AddrWidth-1:0] mem_address_o,
  input logic [trp_pkg::DataWidth-1:0] mem_data_o,
  input logic [trp_pkg::PtrWidth-1:0]  pointer_after_o
);

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> read_data_o == '0)
    else $error("read data is not zero");

  a_no_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mem_write_o) |-> (mem_address_o == '0 && mem_data_o == '0))
    else $error("memory fields set without a memory write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pointer_after_o)))
    else $error("stalled result changed");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_fill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && in_valid_i && out_valid_o && out_stall_i) |=> in_stall_o)
    else $error("result buffer overrun");

endmodule

bind text_ram_register_port_core trp_checker u_trp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .read_data_o    (read_data_o),
  .mem_write_o    (mem_write_o),
  .mem_address_o  (mem_address_o),
  .mem_data_o     (mem_data_o),
  .pointer_after_o(pointer_after_o)
);
